// ===== src/llvs_pkg.sv =====
// ============================================================================
// Lane line vector selector package
// Shared constants, register indexes and transaction types of the selector.
// ============================================================================
package llvs_pkg;

    localparam int SIDE_CAPACITY = 10;
    localparam int COUNT_W       = $clog2(SIDE_CAPACITY + 1);
    localparam int EDGE_MARGIN_X = 33;
    localparam int EDGE_MARGIN_Y = 13;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SLOPE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH   = 2'd3;

    localparam logic [7:0]  FRAME_WIDTH_RESET  = 8'd79;
    localparam logic [7:0]  FRAME_HEIGHT_RESET = 8'd52;
    localparam logic [11:0] MIN_SLOPE_RESET    = 12'd93;
    localparam logic [7:0]  MIN_LENGTH_RESET   = 8'd10;

    typedef struct packed {
        logic [7:0] start_x;
        logic [7:0] start_y;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic       has_segment;
        logic       end_of_frame;
    } seg_in_t;

    typedef struct packed {
        logic       found_left;
        logic [7:0] left_head_x;
        logic       found_right;
        logic [7:0] right_head_x;
        logic       line_seen;
    } lane_out_t;

endpackage

// ===== src/lane_line_vector_selector_core.sv =====
// ============================================================================
// Lane line vector selector core
// Sorts a frame's line segments into left and right track lines, keeps the
// longest per side and reports both head positions at the end of each frame.
// ============================================================================
//
//  Channel   Ports                          Carries
//  -------   ----------------------------   ----------------------------------
//  input     s_valid s_ready s_payload      one segment or frame marker
//  result    m_valid m_ready m_payload      side flags and head x per frame
//  config    cfg_wr_en cfg_index cfg_wdata  frame size, slope, length limits
//
// Each transaction is registered and evaluated combinationally; a frame-end
// transaction writes the result register; one transaction is taken per cycle.
// Only a frame-end transaction waits, when a previous result is still held.
// Reset (aresetn low, synchronous) restores the register defaults and clears
// the frame state and the remembered lines.
module lane_line_vector_selector_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  llvs_pkg::seg_in_t                   s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output llvs_pkg::lane_out_t                 m_payload,
    input  logic                                cfg_wr_en,
    input  logic [llvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [llvs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW = llvs_pkg::COUNT_W;

    logic [7:0]  frame_width_reg, frame_height_reg, min_length_reg;
    logic [11:0] min_slope_reg;

    logic              in_valid_reg;
    llvs_pkg::seg_in_t in_data_reg;
    logic                m_valid_reg;
    llvs_pkg::lane_out_t m_payload_reg, m_payload_next;

    logic [16:0]   left_best_reg, right_best_reg, left_best_next, right_best_next;
    logic [7:0]    left_head_reg, right_head_reg, left_head_next, right_head_next;
    logic [CW-1:0] left_count_reg, right_count_reg, left_count_next, right_count_next;
    logic          crossing_reg, crossing_next, any_seen_reg, any_seen_next;
    logic          mem_has_left_reg, mem_has_right_reg;
    logic          mem_has_left_next, mem_has_right_next;
    logic [7:0]    mem_left_x_reg, mem_right_x_reg, mem_left_x_next, mem_right_x_next;

    logic        fire;
    logic [7:0]  adx, ady, lx0, ly0, lx1, ly1, hx;
    logic [16:0] len_sq;
    logic [15:0] min_len_sq;
    logic [19:0] slope_prod, rise_sh;
    logic        noise, flat, edge_drop, go_left, take;
    logic        hl, hr;
    logic [7:0]  lx, rx;

    assign fire    = in_valid_reg && (!in_data_reg.end_of_frame || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        adx = (in_data_reg.end_x >= in_data_reg.start_x) ?
              in_data_reg.end_x - in_data_reg.start_x : in_data_reg.start_x - in_data_reg.end_x;
        ady = (in_data_reg.end_y >= in_data_reg.start_y) ?
              in_data_reg.end_y - in_data_reg.start_y : in_data_reg.start_y - in_data_reg.end_y;
        len_sq     = 17'(16'(adx) * 16'(adx)) + 17'(16'(ady) * 16'(ady));
        min_len_sq = 16'(min_length_reg) * 16'(min_length_reg);
        noise      = len_sq < {1'b0, min_len_sq};

        if (in_data_reg.start_y < in_data_reg.end_y) begin
            lx0 = in_data_reg.end_x;   ly0 = in_data_reg.end_y;
            lx1 = in_data_reg.start_x; ly1 = in_data_reg.start_y;
        end else begin
            lx0 = in_data_reg.start_x; ly0 = in_data_reg.start_y;
            lx1 = in_data_reg.end_x;   ly1 = in_data_reg.end_y;
        end

        slope_prod = 20'(min_slope_reg) * 20'(adx);
        rise_sh    = {4'b0, ady, 8'b0};
        if (adx == 8'd0 && ady == 8'd0) begin
            flat = min_slope_reg != 12'd0;
        end else begin
            flat = rise_sh < slope_prod;
        end

        edge_drop = (({1'b0, lx1} + 9'(llvs_pkg::EDGE_MARGIN_X) > {1'b0, frame_width_reg}) &&
                     ({1'b0, lx0} + 9'(llvs_pkg::EDGE_MARGIN_X) > {1'b0, frame_width_reg})) ||
                    ((lx1 < 8'(llvs_pkg::EDGE_MARGIN_X)) && (lx0 < 8'(llvs_pkg::EDGE_MARGIN_X))) ||
                    ({1'b0, ly1} + 9'(llvs_pkg::EDGE_MARGIN_Y) > {1'b0, frame_height_reg}) ||
                    (ly0 < 8'(llvs_pkg::EDGE_MARGIN_Y));

        hx      = (ly1 < ly0) ? lx1 : lx0;
        go_left = lx0 < {1'b0, frame_width_reg[7:1]};
        take    = in_data_reg.has_segment && !noise && !flat && !edge_drop;

        left_best_next   = left_best_reg;
        left_head_next   = left_head_reg;
        left_count_next  = left_count_reg;
        right_best_next  = right_best_reg;
        right_head_next  = right_head_reg;
        right_count_next = right_count_reg;
        crossing_next    = crossing_reg || (in_data_reg.has_segment && !noise && flat);
        any_seen_next    = any_seen_reg || in_data_reg.has_segment;

        if (take && go_left && left_count_reg < CW'(llvs_pkg::SIDE_CAPACITY)) begin
            if (left_count_reg == '0 || len_sq > left_best_reg) begin
                left_best_next = len_sq;
                left_head_next = hx;
            end
            left_count_next = left_count_reg + CW'(1);
        end
        if (take && !go_left && right_count_reg < CW'(llvs_pkg::SIDE_CAPACITY)) begin
            if (right_count_reg == '0 || len_sq > right_best_reg) begin
                right_best_next = len_sq;
                right_head_next = hx;
            end
            right_count_next = right_count_reg + CW'(1);
        end

        hl = 1'b0; lx = 8'd0; hr = 1'b0; rx = 8'd0;
        mem_has_left_next  = mem_has_left_reg;
        mem_has_right_next = mem_has_right_reg;
        mem_left_x_next    = mem_left_x_reg;
        mem_right_x_next   = mem_right_x_reg;
        if (any_seen_next) begin
            if (left_count_next != '0) begin
                hl = 1'b1;
                lx = left_head_next;
            end
            if (right_count_next != '0) begin
                hr = 1'b1;
                rx = right_head_next;
            end
            if (!hl && !hr && crossing_next) begin
                hl = mem_has_left_reg;  lx = mem_left_x_reg;
                hr = mem_has_right_reg; rx = mem_right_x_reg;
            end
            mem_has_left_next  = hl;
            mem_has_right_next = hr;
            if (hl) begin
                mem_left_x_next = lx;
            end
            if (hr) begin
                mem_right_x_next = rx;
            end
        end

        m_payload_next.found_left   = hl;
        m_payload_next.left_head_x  = lx;
        m_payload_next.found_right  = hr;
        m_payload_next.right_head_x = rx;
        m_payload_next.line_seen    = hl | hr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= llvs_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= llvs_pkg::FRAME_HEIGHT_RESET;
            min_slope_reg    <= llvs_pkg::MIN_SLOPE_RESET;
            min_length_reg   <= llvs_pkg::MIN_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                llvs_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[7:0];
                llvs_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[7:0];
                llvs_pkg::CFG_MIN_SLOPE:    min_slope_reg    <= cfg_wdata[11:0];
                llvs_pkg::CFG_MIN_LENGTH:   min_length_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
        if (fire && in_data_reg.end_of_frame) begin
            m_payload_reg <= m_payload_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            left_best_reg     <= '0;
            left_head_reg     <= '0;
            left_count_reg    <= '0;
            right_best_reg    <= '0;
            right_head_reg    <= '0;
            right_count_reg   <= '0;
            crossing_reg      <= 1'b0;
            any_seen_reg      <= 1'b0;
            mem_has_left_reg  <= 1'b0;
            mem_has_right_reg <= 1'b0;
            mem_left_x_reg    <= '0;
            mem_right_x_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire && in_data_reg.end_of_frame) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fire) begin
                if (in_data_reg.end_of_frame) begin
                    left_best_reg     <= '0;
                    left_head_reg     <= '0;
                    left_count_reg    <= '0;
                    right_best_reg    <= '0;
                    right_head_reg    <= '0;
                    right_count_reg   <= '0;
                    crossing_reg      <= 1'b0;
                    any_seen_reg      <= 1'b0;
                    mem_has_left_reg  <= mem_has_left_next;
                    mem_has_right_reg <= mem_has_right_next;
                    mem_left_x_reg    <= mem_left_x_next;
                    mem_right_x_reg   <= mem_right_x_next;
                end else begin
                    left_best_reg   <= left_best_next;
                    left_head_reg   <= left_head_next;
                    left_count_reg  <= left_count_next;
                    right_best_reg  <= right_best_next;
                    right_head_reg  <= right_head_next;
                    right_count_reg <= right_count_next;
                    crossing_reg    <= crossing_next;
                    any_seen_reg    <= any_seen_next;
                end
            end
        end
    end

endmodule
